// ----- rtl/core/ffa_pkg.sv -----
// Shared constants, types and helpers of the first-fit heap allocator.
package ffa_pkg;

  // Heap geometry
  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned GRANULE_BYTES = 64;
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned SLOTS         = HEAP_BYTES / HEADER_BYTES;
  localparam int unsigned IDX_W         = $clog2(SLOTS);
  localparam int unsigned LINK_W        = IDX_W + 1;
  localparam int unsigned HDR_SHIFT     = $clog2(HEADER_BYTES);

  // Field and datapath widths
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned NEED_W     = 17;
  localparam int unsigned MSPLIT_W   = 17;
  localparam int unsigned OFF_W      = 18;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [LINK_W-1:0]   NO_LINK         = LINK_W'(SLOTS);
  localparam logic [MSPLIT_W-1:0] MIN_SPLIT_RESET = MSPLIT_W'(64);
  localparam logic [NEED_W-1:0]   NEED_MASK       = ~NEED_W'(GRANULE_BYTES - 1);

  // Commands and status codes
  localparam logic       CMD_ALLOC        = 1'b0;
  localparam logic       CMD_FREE         = 1'b1;
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
  localparam logic [1:0] STATUS_NULL_FREE = 2'd2;

  // Register word index of min_split_bytes
  localparam logic [APB_ADDR_W-3:0] REG_MIN_SPLIT = '0;

  typedef struct packed {
    logic              command;
    logic [15:0]       request_bytes;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] address;
  } out_item_t;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  localparam hdr_t HDR_RESET = '{link: NO_LINK, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    hdr_t             wr_data;
  } ram_req_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [OFF_W-1:0] a;
    logic [OFF_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] res;
    logic             ge;
    logic             eq;
  } alu_rsp_t;

  // Out-of-range links read as end of list
  function automatic logic [LINK_W-1:0] link_norm(input logic [LINK_W-1:0] v);
    return (v < LINK_W'(SLOTS)) ? v : NO_LINK;
  endfunction

  // Byte offset of a header
  function automatic logic [OFF_W-1:0] hdr_off(input logic [IDX_W-1:0] idx);
    return OFF_W'(idx) << HDR_SHIFT;
  endfunction

  // Byte offset just past a header (payload start)
  function automatic logic [OFF_W-1:0] hdr_end(input logic [IDX_W-1:0] idx);
    return (OFF_W'(idx) + OFF_W'(1)) << HDR_SHIFT;
  endfunction

endpackage

// ----- rtl/core/ffa_alu.sv -----
// Shared add / subtract-compare unit of the allocator sequencer.
module ffa_alu (
  input  ffa_pkg::alu_req_t req_i,
  output ffa_pkg::alu_rsp_t rsp_o
);

  logic [ffa_pkg::OFF_W:0] diff;

  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_comb begin
    case (req_i.op)
      ffa_pkg::ALU_ADD: rsp_o.res = req_i.a + req_i.b;
      ffa_pkg::ALU_SUB: rsp_o.res = diff[ffa_pkg::OFF_W-1:0];
      default:          rsp_o.res = diff[ffa_pkg::OFF_W-1:0];
    endcase
    rsp_o.ge = ~diff[ffa_pkg::OFF_W];
    rsp_o.eq = (req_i.a == req_i.b);
  end

endmodule

// ----- rtl/core/ffa_hdr_ram.sv -----
// Header store: one size/link word per header slot, registered read.
module ffa_hdr_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffa_pkg::ram_req_t req_i,
  output ffa_pkg::hdr_t     rd_data_o
);

  ffa_pkg::hdr_t mem [ffa_pkg::SLOTS];
  ffa_pkg::hdr_t rd_data_q;
  logic          init0_q;    // entry 0 still holds its reset header
  logic          rd_init_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q   <= 1'b1;
      rd_init_q <= 1'b0;
    end else begin
      if (req_i.wr_en && (req_i.wr_addr == '0)) begin
        init0_q <= 1'b0;
      end
      if (req_i.rd_en) begin
        rd_init_q <= init0_q && (req_i.rd_addr == '0);
      end
    end
  end

  assign rd_data_o = rd_init_q ? ffa_pkg::HDR_RESET : rd_data_q;

endmodule

// ----- rtl/core/ffa_ctrl.sv -----
// Allocator sequencer: free-list walk, split and coalesce over a shared ALU.
module ffa_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  ffa_pkg::in_item_t              item_i,
  input  logic [ffa_pkg::MSPLIT_W-1:0]   min_split_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output ffa_pkg::out_item_t             res_o,
  input  logic                           res_ack_i
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_NEED,
    S_A_CHK,
    S_A_SPL1,
    S_A_SPL2,
    S_A_SPL3,
    S_A_SPL4,
    S_A_LINK,
    S_F_START,
    S_F_CHK,
    S_F_RDP,
    S_F_PD,
    S_F_BK,
    S_F_BM1,
    S_F_BM2,
    S_F_FWD1,
    S_F_FWD2,
    S_F_FM1,
    S_F_FM2,
    S_F_WR,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  ffa_pkg::in_item_t             item_q, item_d;
  logic [ffa_pkg::LINK_W-1:0]    head_q, head_d;
  logic [ffa_pkg::LINK_W-1:0]    cur_q, cur_d;
  logic [ffa_pkg::LINK_W-1:0]    prev_q, prev_d;
  logic [ffa_pkg::SIZE_W-1:0]    prev_size_q, prev_size_d;
  logic [ffa_pkg::SIZE_W-1:0]    cur_size_q, cur_size_d;
  logic [ffa_pkg::LINK_W-1:0]    cur_link_q, cur_link_d;
  logic [ffa_pkg::NEED_W-1:0]    need_q, need_d;
  logic [ffa_pkg::NEED_W-1:0]    rem_q, rem_d;
  logic                          split_ok_q, split_ok_d;
  logic [ffa_pkg::IDX_W-1:0]     steps_q, steps_d;
  logic [ffa_pkg::IDX_W-1:0]     p_q, p_d;
  logic [ffa_pkg::IDX_W-1:0]     nidx_q, nidx_d;
  logic [ffa_pkg::IDX_W-1:0]     t_q, t_d;
  logic [ffa_pkg::SIZE_W-1:0]    tsize_q, tsize_d;
  logic [ffa_pkg::LINK_W-1:0]    tlink_q, tlink_d;
  logic [ffa_pkg::OFF_W-1:0]     acc_q, acc_d;
  ffa_pkg::out_item_t            res_q, res_d;

  ffa_pkg::alu_req_t             alu_req;
  ffa_pkg::alu_rsp_t             alu_rsp;
  ffa_pkg::ram_req_t             ram_req;
  ffa_pkg::hdr_t                 rd_hdr;
  logic [ffa_pkg::LINK_W-1:0]    nxt_link;
  logic                          walk_end;
  logic [ffa_pkg::ADDR_W-1:0]    faddr;

  ffa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ffa_hdr_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (rd_hdr)
  );

  // Next link of the header under inspection, and walk limit
  assign nxt_link = ffa_pkg::link_norm(rd_hdr.link);
  assign walk_end = (nxt_link == ffa_pkg::NO_LINK) ||
                    (steps_q == ffa_pkg::IDX_W'(ffa_pkg::SLOTS - 1));
  assign faddr    = item_q.block_address;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    head_d      = head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_size_d = prev_size_q;
    cur_size_d  = cur_size_q;
    cur_link_d  = cur_link_q;
    need_d      = need_q;
    rem_d       = rem_q;
    split_ok_d  = split_ok_q;
    steps_d     = steps_q;
    p_d         = p_q;
    nidx_d      = nidx_q;
    t_d         = t_q;
    tsize_d     = tsize_q;
    tlink_d     = tlink_q;
    acc_d       = acc_q;
    res_d       = res_q;
    ram_req     = '0;
    alu_req     = '{op: ffa_pkg::ALU_ADD, a: '0, b: '0};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d  = item_i;
          state_d = (item_i.command == ffa_pkg::CMD_FREE) ? S_F_START : S_A_NEED;
        end
      end

      // ---------------- allocate ----------------
      S_A_NEED: begin
        alu_req = '{op: ffa_pkg::ALU_ADD,
                    a: ffa_pkg::OFF_W'(item_q.request_bytes),
                    b: ffa_pkg::OFF_W'(ffa_pkg::GRANULE_BYTES - 1)};
        need_d  = alu_rsp.res[ffa_pkg::NEED_W-1:0] & ffa_pkg::NEED_MASK;
        prev_d  = ffa_pkg::NO_LINK;
        steps_d = '0;
        cur_d   = ffa_pkg::link_norm(head_q);
        if (ffa_pkg::link_norm(head_q) == ffa_pkg::NO_LINK) begin
          res_d   = '{status: ffa_pkg::STATUS_NO_FIT, address: '0};
          state_d = S_DONE;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = head_q[ffa_pkg::IDX_W-1:0];
          state_d         = S_A_CHK;
        end
      end

      S_A_CHK: begin
        alu_req = '{op: ffa_pkg::ALU_SUB,
                    a: ffa_pkg::OFF_W'(rd_hdr.size),
                    b: ffa_pkg::OFF_W'(need_q)};
        if (alu_rsp.ge) begin
          rem_d      = alu_rsp.res[ffa_pkg::NEED_W-1:0];
          cur_link_d = rd_hdr.link;
          state_d    = S_A_SPL1;
        end else begin
          prev_d      = cur_q;
          prev_size_d = rd_hdr.size;
          steps_d     = steps_q + 1'b1;
          if (walk_end) begin
            res_d   = '{status: ffa_pkg::STATUS_NO_FIT, address: '0};
            state_d = S_DONE;
          end else begin
            cur_d           = nxt_link;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = nxt_link[ffa_pkg::IDX_W-1:0];
          end
        end
      end

      S_A_SPL1: begin
        alu_req = '{op: ffa_pkg::ALU_SUB,
                    a: ffa_pkg::OFF_W'(rem_q),
                    b: ffa_pkg::OFF_W'(min_split_i)};
        split_ok_d = alu_rsp.ge && (rem_q >= ffa_pkg::NEED_W'(ffa_pkg::HEADER_BYTES));
        state_d    = S_A_SPL2;
      end

      S_A_SPL2: begin
        // header of the remainder sits right after the granted payload
        alu_req = '{op: ffa_pkg::ALU_ADD,
                    a: ffa_pkg::hdr_end(cur_q[ffa_pkg::IDX_W-1:0]),
                    b: ffa_pkg::OFF_W'(need_q)};
        nidx_d  = alu_rsp.res[ffa_pkg::HDR_SHIFT +: ffa_pkg::IDX_W];
        if (split_ok_q && (alu_rsp.res < ffa_pkg::OFF_W'(ffa_pkg::HEAP_BYTES))) begin
          state_d = S_A_SPL3;
        end else begin
          tlink_d = ffa_pkg::link_norm(cur_link_q);
          state_d = S_A_LINK;
        end
      end

      S_A_SPL3: begin
        alu_req = '{op: ffa_pkg::ALU_SUB,
                    a: ffa_pkg::OFF_W'(rem_q),
                    b: ffa_pkg::OFF_W'(ffa_pkg::HEADER_BYTES)};
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = nidx_q;
        ram_req.wr_data = '{link: ffa_pkg::link_norm(cur_link_q),
                            size: alu_rsp.res[ffa_pkg::SIZE_W-1:0]};
        state_d         = S_A_SPL4;
      end

      S_A_SPL4: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = cur_q[ffa_pkg::IDX_W-1:0];
        ram_req.wr_data = '{link: cur_link_q, size: need_q[ffa_pkg::SIZE_W-1:0]};
        tlink_d         = ffa_pkg::LINK_W'(nidx_q);
        state_d         = S_A_LINK;
      end

      S_A_LINK: begin
        if (prev_q == ffa_pkg::NO_LINK) begin
          head_d = tlink_q;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = prev_q[ffa_pkg::IDX_W-1:0];
          ram_req.wr_data = '{link: tlink_q, size: prev_size_q};
        end
        res_d   = '{status: ffa_pkg::STATUS_OK,
                    address: ffa_pkg::hdr_end(cur_q[ffa_pkg::IDX_W-1:0])
                             [ffa_pkg::ADDR_W-1:0]};
        state_d = S_DONE;
      end

      // ---------------- free ----------------
      S_F_START: begin
        res_d   = '{status: ffa_pkg::STATUS_OK, address: '0};
        prev_d  = ffa_pkg::NO_LINK;
        steps_d = '0;
        p_d     = ffa_pkg::IDX_W'((faddr >> ffa_pkg::HDR_SHIFT) - ffa_pkg::ADDR_W'(1));
        cur_d   = ffa_pkg::link_norm(head_q);
        if (faddr == '0) begin
          res_d   = '{status: ffa_pkg::STATUS_NULL_FREE, address: '0};
          state_d = S_DONE;
        end else if ((faddr < ffa_pkg::ADDR_W'(ffa_pkg::HEADER_BYTES)) ||
                     (faddr[ffa_pkg::HDR_SHIFT-1:0] != '0) ||
                     ((ffa_pkg::OFF_W'(faddr) >> ffa_pkg::HDR_SHIFT) >
                      ffa_pkg::OFF_W'(ffa_pkg::SLOTS))) begin
          // bad pointer: ignored
          state_d = S_DONE;
        end else if (ffa_pkg::link_norm(head_q) == ffa_pkg::NO_LINK) begin
          state_d = S_F_RDP;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = head_q[ffa_pkg::IDX_W-1:0];
          state_d         = S_F_CHK;
        end
      end

      S_F_CHK: begin
        alu_req = '{op: ffa_pkg::ALU_SUB,
                    a: ffa_pkg::OFF_W'(cur_q),
                    b: ffa_pkg::OFF_W'(p_q)};
        if (alu_rsp.eq) begin
          // already free
          state_d = S_DONE;
        end else if (alu_rsp.ge) begin
          cur_size_d = rd_hdr.size;
          cur_link_d = rd_hdr.link;
          state_d    = S_F_RDP;
        end else begin
          prev_d      = cur_q;
          prev_size_d = rd_hdr.size;
          steps_d     = steps_q + 1'b1;
          if (walk_end) begin
            cur_d   = ffa_pkg::NO_LINK;
            state_d = S_F_RDP;
          end else begin
            cur_d           = nxt_link;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = nxt_link[ffa_pkg::IDX_W-1:0];
          end
        end
      end

      S_F_RDP: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = p_q;
        state_d         = S_F_PD;
      end

      S_F_PD: begin
        tsize_d = rd_hdr.size;
        t_d     = p_q;
        if (prev_q == ffa_pkg::NO_LINK) begin
          head_d  = ffa_pkg::LINK_W'(p_q);
          state_d = S_F_FWD1;
        end else begin
          alu_req = '{op: ffa_pkg::ALU_ADD,
                      a: ffa_pkg::hdr_end(prev_q[ffa_pkg::IDX_W-1:0]),
                      b: ffa_pkg::OFF_W'(prev_size_q)};
          acc_d   = alu_rsp.res;
          state_d = S_F_BK;
        end
      end

      S_F_BK: begin
        alu_req = '{op: ffa_pkg::ALU_SUB, a: acc_q, b: ffa_pkg::hdr_off(p_q)};
        if (alu_rsp.eq) begin
          state_d = S_F_BM1;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = prev_q[ffa_pkg::IDX_W-1:0];
          ram_req.wr_data = '{link: ffa_pkg::LINK_W'(p_q), size: prev_size_q};
          state_d         = S_F_FWD1;
        end
      end

      S_F_BM1: begin
        alu_req = '{op: ffa_pkg::ALU_ADD,
                    a: ffa_pkg::OFF_W'(prev_size_q),
                    b: ffa_pkg::OFF_W'(tsize_q)};
        acc_d   = alu_rsp.res;
        state_d = S_F_BM2;
      end

      S_F_BM2: begin
        alu_req = '{op: ffa_pkg::ALU_ADD, a: acc_q,
                    b: ffa_pkg::OFF_W'(ffa_pkg::HEADER_BYTES)};
        tsize_d = alu_rsp.res[ffa_pkg::SIZE_W-1:0];
        t_d     = prev_q[ffa_pkg::IDX_W-1:0];
        state_d = S_F_FWD1;
      end

      S_F_FWD1: begin
        tlink_d = cur_q;
        if (cur_q == ffa_pkg::NO_LINK) begin
          state_d = S_F_WR;
        end else begin
          alu_req = '{op: ffa_pkg::ALU_ADD,
                      a: ffa_pkg::hdr_end(t_q),
                      b: ffa_pkg::OFF_W'(tsize_q)};
          acc_d   = alu_rsp.res;
          state_d = S_F_FWD2;
        end
      end

      S_F_FWD2: begin
        alu_req = '{op: ffa_pkg::ALU_SUB, a: acc_q,
                    b: ffa_pkg::hdr_off(cur_q[ffa_pkg::IDX_W-1:0])};
        if (alu_rsp.eq) begin
          tlink_d = ffa_pkg::link_norm(cur_link_q);
          state_d = S_F_FM1;
        end else begin
          state_d = S_F_WR;
        end
      end

      S_F_FM1: begin
        alu_req = '{op: ffa_pkg::ALU_ADD,
                    a: ffa_pkg::OFF_W'(tsize_q),
                    b: ffa_pkg::OFF_W'(cur_size_q)};
        acc_d   = alu_rsp.res;
        state_d = S_F_FM2;
      end

      S_F_FM2: begin
        alu_req = '{op: ffa_pkg::ALU_ADD, a: acc_q,
                    b: ffa_pkg::OFF_W'(ffa_pkg::HEADER_BYTES)};
        tsize_d = alu_rsp.res[ffa_pkg::SIZE_W-1:0];
        state_d = S_F_WR;
      end

      S_F_WR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = t_q;
        ram_req.wr_data = '{link: tlink_q, size: tsize_q};
        state_d         = S_DONE;
      end

      S_DONE: begin
        if (res_ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      head_q      <= '0;
      cur_q       <= ffa_pkg::NO_LINK;
      prev_q      <= ffa_pkg::NO_LINK;
      prev_size_q <= '0;
      cur_size_q  <= '0;
      cur_link_q  <= '0;
      need_q      <= '0;
      rem_q       <= '0;
      split_ok_q  <= 1'b0;
      steps_q     <= '0;
      p_q         <= '0;
      nidx_q      <= '0;
      t_q         <= '0;
      tsize_q     <= '0;
      tlink_q     <= '0;
      acc_q       <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      head_q      <= head_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      prev_size_q <= prev_size_d;
      cur_size_q  <= cur_size_d;
      cur_link_q  <= cur_link_d;
      need_q      <= need_d;
      rem_q       <= rem_d;
      split_ok_q  <= split_ok_d;
      steps_q     <= steps_d;
      p_q         <= p_d;
      nidx_q      <= nidx_d;
      t_q         <= t_d;
      tsize_q     <= tsize_d;
      tlink_q     <= tlink_d;
      acc_q       <= acc_d;
      res_q       <= res_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // The store is never read and written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.rd_en && ram_req.wr_en))
    else $error("header store read and written in one cycle");

  // Walk states always inspect a real header
  a_walk_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_CHK || state_q == S_F_CHK) |-> (cur_q != ffa_pkg::NO_LINK))
    else $error("list walk on a null link");

  // A split-off header lies above the block it came from
  a_split_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SPL3) |-> (nidx_q > cur_q[ffa_pkg::IDX_W-1:0]))
    else $error("split header not above its block");

  // Idle sequencer leaves the store alone
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!ram_req.rd_en && !ram_req.wr_en))
    else $error("store access while idle");

  // A result is held until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ack_i) |=> (res_valid_o && $stable(res_o)))
    else $error("pending result lost");

endmodule

// ----- rtl/core/first_fit_heap_allocator_core.sv -----
// Top level of the first-fit heap allocator: item channels, APB register, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one command per
//   item: allocate request_bytes, or free block_address. Output channel
//   (out_valid_o / out_stall_i / out_item_o) returns one status/address per item.
//   An item moves at a clock edge with valid high and stall low.
// Timing:
//   Allocate time grows with the free blocks visited, plus split writes when a block
//   splits. Free time grows with the free blocks below the freed one; a null or
//   malformed pointer skips the walk. One header read per cycle during the walk, so
//   list length sets the rate; the next item is taken in the cycle after the result loads.
// Stalls:
//   A finished result sits in the output register; the next item is taken
//   while it waits. If a second result is ready before the first leaves,
//   the sequencer holds until the register frees.
// Reset:
//   The heap is one free block at offset 0, min_split_bytes = 64. No clearing
//   pass: only header 0 carries a reset value, so items are taken at once.
// Config:
//   min_split_bytes at APB byte address 0; write only while idle.
module first_fit_heap_allocator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ffa_pkg::in_item_t                  in_item_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ffa_pkg::out_item_t                 out_item_o,
  // APB register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ffa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ffa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ffa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic                          busy;
  logic                          start;
  logic                          res_valid;
  logic                          res_ack;
  ffa_pkg::out_item_t            res;
  logic                          out_valid_q, out_valid_d;
  ffa_pkg::out_item_t            out_item_q, out_item_d;
  logic [ffa_pkg::MSPLIT_W-1:0]  min_split_q, min_split_d;
  logic                          reg_hit;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (in_item_i),
    .min_split_i (min_split_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack)
  );

  // Item accepted whenever the sequencer is idle
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  // Result register: loads when empty or being drained
  assign res_ack = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_ack) begin
      out_valid_d = 1'b1;
      out_item_d  = res;
    end
  end

  // Register decode: word address selects the register
  assign reg_hit = (paddr[ffa_pkg::APB_ADDR_W-1:2] == ffa_pkg::REG_MIN_SPLIT);

  always_comb begin
    min_split_d = min_split_q;
    if (psel && penable && pwrite && reg_hit) begin
      min_split_d = pwdata[ffa_pkg::MSPLIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      min_split_q <= ffa_pkg::MIN_SPLIT_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
      min_split_q <= min_split_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign pready      = 1'b1;
  assign prdata      = reg_hit ? ffa_pkg::APB_DATA_W'(min_split_q) : '0;

endmodule

// ----- tb/tb_first_fit_heap_allocator_core.sv -----
// Self-checking testbench for the first-fit heap allocator core.
module tb_first_fit_heap_allocator_core;
  import ffa_pkg::*;

  // Cycles with no item moving on either channel before the run is declared hung.
  // The slowest legal item walks at most SLOTS headers, plus sender gaps and sink stalls.
  localparam int unsigned QUIET_LIMIT      = 20000;
  // Cycles allowed after the last result before a register write or the verdict.
  localparam int unsigned SETTLE_CYCLES    = 32;
  localparam int unsigned RANDOM_PER_PHASE = 140;
  // The result sink goes deaf for this long once, to back the block up.
  localparam int unsigned JAM_AFTER        = 250;
  localparam int unsigned JAM_CYCLES       = 400;
  localparam int unsigned MAX_PRINTED      = 100;

  // One row of the directed table. Rows with known_res set carry their result;
  // the rest are checked against the heap predictor.
  typedef struct packed {
    logic      cmd;
    logic [15:0] req;
    logic [15:0] addr;
    logic      known_res;
    out_item_t res;
  } probe_t;

  localparam int unsigned NUM_PROBES = 22;
  localparam probe_t PROBES [NUM_PROBES] = '{
    // Fresh heap, split threshold at its reset value of 64
    '{CMD_ALLOC, 16'd0,     16'd0,     1'b1, '{STATUS_OK, 16'd16}},     // zero request splits
    '{CMD_ALLOC, 16'd1,     16'd0,     1'b1, '{STATUS_OK, 16'd32}},     // rounds to one granule
    '{CMD_ALLOC, 16'd65535, 16'd0,     1'b1, '{STATUS_NO_FIT, 16'd0}},  // larger than heap
    '{CMD_FREE,  16'd0,     16'd0,     1'b1, '{STATUS_NULL_FREE, 16'd0}},
    '{CMD_FREE,  16'd0,     16'd15,    1'b1, '{STATUS_OK, 16'd0}},      // below header size
    '{CMD_FREE,  16'd0,     16'd33,    1'b1, '{STATUS_OK, 16'd0}},      // off header boundary
    '{CMD_FREE,  16'hffff,  16'd65535, 1'b1, '{STATUS_OK, 16'd0}},      // top address, odd
    '{CMD_FREE,  16'd0,     16'd112,   1'b1, '{STATUS_OK, 16'd0}},      // block already free
    '{CMD_FREE,  16'd0,     16'd32,    1'b0, '0},                       // merges with next
    '{CMD_FREE,  16'd0,     16'd16,    1'b0, '0},                       // merges back to one
    '{CMD_ALLOC, 16'd65472, 16'hffff,  1'b1, '{STATUS_OK, 16'd16}},     // remainder kept
    '{CMD_ALLOC, 16'd0,     16'd0,     1'b1, '{STATUS_NO_FIT, 16'd0}},  // empty free list
    '{CMD_FREE,  16'd0,     16'd16,    1'b0, '0},
    '{CMD_ALLOC, 16'd65520, 16'd0,     1'b1, '{STATUS_NO_FIT, 16'd0}},  // rounds past heap
    '{CMD_ALLOC, 16'd100,   16'd0,     1'b0, '0},
    '{CMD_ALLOC, 16'd64,    16'd0,     1'b0, '0},
    '{CMD_ALLOC, 16'd200,   16'd0,     1'b0, '0},
    '{CMD_FREE,  16'd0,     16'd160,   1'b0, '0},                       // hole, no neighbor
    '{CMD_ALLOC, 16'd0,     16'd0,     1'b0, '0},                       // zero block in hole
    '{CMD_FREE,  16'd0,     16'd16,    1'b0, '0},
    '{CMD_FREE,  16'd0,     16'd160,   1'b0, '0},                       // merges both sides
    '{CMD_FREE,  16'd0,     16'd240,   1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  first_fit_heap_allocator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Heap image kept by the testbench: payload size and next-free link per header slot.
  // A link of SLOTS marks the end of the free list.
  int unsigned blk_size [SLOTS];
  int unsigned blk_link [SLOTS];
  int unsigned list_head;
  int unsigned split_floor;

  out_item_t   owed_replies [$];   // results still due, oldest first
  logic [15:0] live_ptrs [$];      // payload offsets handed out and not yet freed
  int unsigned mismatches;
  int unsigned replies_seen;
  bit          feed_calm;          // sender runs without gaps for a stretch
  bit          sink_calm;          // receiver runs without stalls for a stretch
  bit          jam_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------

  function automatic void heap_reset();
    foreach (blk_size[i]) begin
      blk_size[i] = 0;
      blk_link[i] = 0;
    end
    blk_size[0] = HEAP_BYTES - HEADER_BYTES;
    blk_link[0] = SLOTS;
    list_head   = 0;
    split_floor = 32'(MIN_SPLIT_RESET);
  endfunction

  // Links that point outside the store read as end of list.
  function automatic int unsigned next_of(int unsigned i);
    if (i >= SLOTS) return SLOTS;
    return (blk_link[i] < SLOTS) ? blk_link[i] : SLOTS;
  endfunction

  // First fit over the address-ordered list; split off the tail when it is big enough.
  function automatic out_item_t heap_carve(logic [15:0] req);
    longint unsigned need, rem, nxt_off;
    int unsigned     cur, prev, repl, steps, n;
    bit              found;
    out_item_t       r;
    need  = ((64'(req) + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
    cur   = (list_head < SLOTS) ? list_head : SLOTS;
    prev  = SLOTS;
    steps = 0;
    found = 1'b0;
    while (cur != SLOTS && steps < SLOTS) begin
      if (64'(blk_size[cur]) >= need) begin
        found = 1'b1;
        break;
      end
      prev = cur;
      cur  = next_of(cur);
      steps++;
    end
    r.status  = STATUS_NO_FIT;
    r.address = '0;
    if (!found) return r;
    rem     = 64'(blk_size[cur]) - need;
    nxt_off = 64'(cur) * HEADER_BYTES + HEADER_BYTES + need;
    if (rem >= split_floor && rem >= HEADER_BYTES &&
        nxt_off % HEADER_BYTES == 0 && nxt_off / HEADER_BYTES < SLOTS) begin
      n           = 32'(nxt_off / HEADER_BYTES);
      blk_size[n] = 32'(rem - HEADER_BYTES);
      blk_link[n] = next_of(cur);
      blk_size[cur] = 32'(need);
      repl        = n;
    end else begin
      repl = next_of(cur);
    end
    if (prev == SLOTS) list_head = repl;
    else blk_link[prev] = repl;
    r.status  = STATUS_OK;
    r.address = 16'(64'(cur) * HEADER_BYTES + HEADER_BYTES);
    return r;
  endfunction

  // Insert in address order, then coalesce with the free neighbors on either side.
  function automatic out_item_t heap_return(logic [15:0] addr);
    longint unsigned hoff;
    int unsigned     p, cur, prev, steps;
    out_item_t       r;
    r.address = '0;
    r.status  = STATUS_OK;
    if (addr == '0) begin
      r.status = STATUS_NULL_FREE;
      return r;
    end
    // malformed offsets are dropped silently
    if (addr < HEADER_BYTES) return r;
    hoff = 64'(addr) - HEADER_BYTES;
    if (hoff % HEADER_BYTES != 0 || hoff / HEADER_BYTES >= SLOTS) return r;
    p     = 32'(hoff / HEADER_BYTES);
    cur   = (list_head < SLOTS) ? list_head : SLOTS;
    prev  = SLOTS;
    steps = 0;
    while (cur != SLOTS && steps < SLOTS) begin
      if (cur == p) return r;   // already on the list
      if (cur > p) break;
      prev = cur;
      cur  = next_of(cur);
      steps++;
    end
    if (steps >= SLOTS) cur = SLOTS;
    if (prev != SLOTS) begin
      blk_link[prev] = p;
      if (64'(prev) * HEADER_BYTES + HEADER_BYTES + blk_size[prev] ==
          64'(p) * HEADER_BYTES) begin
        blk_size[prev] += blk_size[p] + HEADER_BYTES;
        p = prev;
      end
    end else begin
      list_head = p;
    end
    blk_link[p] = cur;
    if (cur != SLOTS &&
        64'(p) * HEADER_BYTES + HEADER_BYTES + blk_size[p] == 64'(cur) * HEADER_BYTES) begin
      blk_link[p] = next_of(cur);
      blk_size[p] += blk_size[cur] + HEADER_BYTES;
    end
    return r;
  endfunction

  function automatic out_item_t heap_apply(in_item_t it);
    if (it.command == CMD_ALLOC) return heap_carve(it.request_bytes);
    return heap_return(it.block_address);
  endfunction

  // Payload offset of a random block that is currently free (0 if none).
  function automatic logic [15:0] listed_block_ptr();
    int unsigned cur, n, pick;
    n   = 0;
    cur = (list_head < SLOTS) ? list_head : SLOTS;
    while (cur != SLOTS && n < SLOTS) begin
      n++;
      cur = next_of(cur);
    end
    if (n == 0) return '0;
    pick = $urandom_range(n - 1);
    cur  = list_head;
    repeat (pick) cur = next_of(cur);
    return 16'((cur + 1) * HEADER_BYTES);
  endfunction

  // Mostly small requests so the free list gets long; a few huge ones hit no-fit.
  function automatic logic [15:0] pick_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(256));
    if (r < 90) return 16'($urandom_range(4096));
    if (r < 98) return 16'($urandom_range(20000));
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Every result that leaves the block is matched against the oldest owed one.
  always @(posedge clk_i) begin : result_check
    out_item_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (owed_replies.size() == 0) begin
        note_mismatch("result with nothing owed, status", out_item_o.status, 0);
      end else begin
        due = owed_replies.pop_front();
        if (out_item_o.status !== due.status)
          note_mismatch("status", out_item_o.status, due.status);
        if (out_item_o.address !== due.address)
          note_mismatch("address", out_item_o.address, due.address);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one command after a random gap. Valid stays high on return so a
  // back-to-back item never drops it; callers lower it before going idle.
  task automatic push_cmd(logic cmd, logic [15:0] req, logic [15:0] addr,
                          logic known_res, out_item_t res);
    int unsigned gap;
    in_item_t    it;
    out_item_t   want;
    if ($urandom_range(40) == 0) feed_calm = ($urandom_range(3) == 0);
    gap = feed_calm ? 0 : $urandom_range(8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.command       = cmd;
    it.request_bytes = req;
    it.block_address = addr;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge: advance the heap image and book the result
    want = heap_apply(it);
    owed_replies.push_back(known_res ? res : want);
    if (cmd == CMD_ALLOC) begin
      if (want.status == STATUS_OK && want.address != '0) live_ptrs.push_back(want.address);
    end else begin
      for (int j = 0; j < live_ptrs.size(); j++) begin
        if (live_ptrs[j] == addr) begin
          live_ptrs.delete(j);
          break;
        end
      end
    end
  endtask

  // Stop offering and wait for every owed result plus the block's tail work.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register takes pwdata at the
  // edge where psel, penable, pwrite and pready are all high.
  task automatic write_split_floor(int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MIN_SPLIT, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    split_floor = value & 32'h1ffff;
  endtask

  // Random traffic: mostly allocate/free of real pointers, some null, malformed and double frees.
  task automatic random_item();
    int unsigned r;
    logic [15:0] a;
    r = $urandom_range(99);
    if (r < 50 || (live_ptrs.size() == 0 && r < 85)) begin
      push_cmd(CMD_ALLOC, pick_request(), 16'($urandom), 1'b0, '0);
    end else if (r < 85) begin
      a = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
      push_cmd(CMD_FREE, 16'($urandom), a, 1'b0, '0);
    end else begin
      case ($urandom_range(4))
        0: push_cmd(CMD_FREE, 16'($urandom), 16'd0, 1'b0, '0);
        1: push_cmd(CMD_FREE, 16'($urandom), 16'($urandom_range(15, 1)), 1'b0, '0);
        2: begin
          a = 16'($urandom);
          if (a[3:0] == 4'd0) a[0] = 1'b1;
          push_cmd(CMD_FREE, 16'($urandom), a, 1'b0, '0);
        end
        3: push_cmd(CMD_FREE, 16'($urandom), listed_block_ptr(), 1'b0, '0);
        default: push_cmd(CMD_ALLOC, 16'($urandom), 16'($urandom), 1'b0, '0);
      endcase
    end
  endtask

  // Result sink: random stalls per item, calm stretches, and one long jam that
  // fills the block so its input stalls while the sender keeps offering.
  initial begin : result_sink
    int unsigned hold;
    out_stall_i <= 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(40) == 0) sink_calm = ($urandom_range(3) == 0);
      if (!jam_done && replies_seen >= JAM_AFTER) begin
        hold     = JAM_CYCLES;
        jam_done = 1'b1;
      end else begin
        hold = sink_calm ? 0 : $urandom_range(8);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Hang detector: counts cycles in which neither channel moves an item.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned split_plan [8];
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    mismatches   = 0;
    replies_seen = 0;
    feed_calm    = 1'b0;
    sink_calm    = 1'b0;
    jam_done     = 1'b0;
    heap_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, run with the reset split threshold.
    foreach (PROBES[k])
      push_cmd(PROBES[k].cmd, PROBES[k].req, PROBES[k].addr, PROBES[k].known_res,
               PROBES[k].res);

    // Threshold sweep: both extremes, just around the header size, and a random pick.
    // Odd phases end by freeing everything so the heap must coalesce back to one block;
    // even phases leave fragments for the next one to fight through.
    split_plan = '{0, 65536, 16, 17, 128, 0, 1000, 64};
    split_plan[5] = $urandom_range(65536);
    foreach (split_plan[ph]) begin
      settle();
      write_split_floor(split_plan[ph]);
      repeat (RANDOM_PER_PHASE) random_item();
      if (ph % 2 == 1) begin
        while (live_ptrs.size() != 0)
          push_cmd(CMD_FREE, 16'($urandom), live_ptrs[$urandom_range(live_ptrs.size() - 1)],
                   1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ffa_pkg.sv
rtl/core/ffa_alu.sv
rtl/core/ffa_hdr_ram.sv
rtl/core/ffa_ctrl.sv
rtl/core/first_fit_heap_allocator_core.sv
tb/tb_first_fit_heap_allocator_core.sv
